// ----- hw/rtl/ueh_pkg.sv -----
package ueh_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // Input modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Result kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Frame bytes.
    localparam logic [7:0] TX_HDR      = 8'hAA;
    localparam logic [7:0] TX_TAIL     = 8'h55;
    localparam logic [7:0] CMD_PREPARE = 8'hAB;
    localparam logic [7:0] CMD_RESET   = 8'h5A;
    localparam logic [7:0] CMD_LEGACY  = 8'hFF;
    localparam logic [7:0] ACK_HDR     = 8'h55;
    localparam logic [7:0] ACK_CMD     = 8'hBA;
    localparam logic [7:0] ACK_TAIL    = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // Register map, by word index.
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TX_WAIT     = 2'd2;
    localparam logic [1:0] REG_LEGACY_GAP  = 2'd3;

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
    localparam logic [7:0] TX_WAIT_RST     = 8'd10;
    localparam logic [7:0] LEGACY_GAP_RST  = 8'd20;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] node_id;
        logic [7:0]  entropy;
        logic [7:0]  rx_byte;
        logic        tx_busy;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic       success;
    } out_item_t;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/update_entry_handshake.sv -----
// Update-entry handshake sequencer. A start transaction derives a nonzero session
// number and sends 8-byte PREPARE frames, then RESET frames, each try waiting for an
// idle transmitter and then for a matching READY acknowledgement; when a command runs
// out of tries, legacy frames go out spaced by a gap and the handshake finishes with
// success low. Input transactions are taken one per cycle while no frame or finish result
// waits for the output register: each is decided in a single pass between the input
// register and the output register. A transaction that sends a frame holds the output
// register until its last byte is taken (one frame byte per cycle while the receiver is
// ready, CRC built as the bytes leave), a finish result until it is taken. Timers count tick
// transactions only. The four configuration registers sit at byte addresses 0, 4, 8, 12.
module update_entry_handshake
    import ueh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,

    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {PH_IDLE, PH_PREPARE, PH_RESET, PH_LEGACY} phase_t;
    typedef enum logic [1:0] {WK_TX, WK_ACK, WK_GAP} wait_t;
    typedef enum logic [1:0] {EM_NONE, EM_FRAME, EM_FINISH} emit_t;

    typedef struct packed {
        phase_t     ph;
        wait_t      wk;
        logic [3:0] att;
        logic [7:0] tc;
        logic [3:0] ack_cnt;
        emit_t      em;
        logic [7:0] cmd;
        logic       ok;
    } ctl_t;

    // Configuration registers.
    logic [3:0] retry_limit_reg;
    logic [7:0] ack_timeout_reg;
    logic [7:0] tx_wait_reg;
    logic [7:0] legacy_gap_reg;
    logic       cfg_write;
    logic [3:0] lim;

    // Sequencer state.
    ctl_t        ctl_reg;
    ctl_t        ctl_next;
    logic [7:0]  cc_reg;
    logic [7:0]  cc_next;
    logic [7:0]  sess_reg;
    logic [7:0]  sess_next;
    logic [23:0] target_reg;
    logic [23:0] target_next;
    logic        ack_ok_reg;
    logic        ack_ok_next;
    logic [7:0]  ack_crc_reg;
    logic [7:0]  ack_crc_next;

    // Input register.
    logic        in_valid_reg;
    in_item_t    in_reg;
    logic        advance;

    // Output job register.
    logic             job_valid_reg;
    logic             job_done_reg;
    logic             job_ok_reg;
    logic [7:0]       job_cmd_reg;
    logic [23:0]      job_id_reg;
    logic [7:0]       job_seq_reg;
    logic [IDX_W-1:0] job_idx_reg;
    logic [7:0]       job_crc_reg;
    logic             job_last;
    logic             job_free;
    logic [7:0]       frame_byte;

    function automatic ctl_t send_cmd(input ctl_t s);
        ctl_t r;
        r     = s;
        r.wk  = WK_ACK;
        r.tc  = '0;
        r.em  = EM_FRAME;
        r.cmd = (s.ph == PH_PREPARE) ? CMD_PREPARE : CMD_RESET;
        return r;
    endfunction

    function automatic ctl_t finish(input ctl_t s, input logic ok);
        ctl_t r;
        r    = s;
        r.em = EM_FINISH;
        r.ok = ok;
        r.ph = PH_IDLE;
        r.wk = WK_TX;
        r.tc = '0;
        return r;
    endfunction

    function automatic ctl_t fail_try(input ctl_t s, input logic [3:0] limit);
        ctl_t r;
        r     = s;
        r.att = s.att + 4'd1;
        if (r.att >= limit)
        begin
            r.ph  = PH_LEGACY;
            r.att = '0;
        end
        return r;
    endfunction

    function automatic ctl_t start_try(input ctl_t s, input logic busy,
                                       input logic [3:0] limit, input logic [7:0] tx_wait);
        ctl_t r;
        r = s;
        if (s.ph == PH_LEGACY)
        begin
            if (s.att >= limit)
            begin
                r = finish(s, 1'b0);
            end
            else if (busy)
            begin
                r.wk = WK_TX;
            end
            else
            begin
                r.wk  = WK_GAP;
                r.tc  = '0;
                r.em  = EM_FRAME;
                r.cmd = CMD_LEGACY;
            end
        end
        else
        begin
            r.ack_cnt = '0;
            r.tc      = '0;
            if (!busy)
            begin
                r = send_cmd(r);
            end
            else if (tx_wait != 8'd0)
            begin
                r.wk = WK_TX;
            end
            else
            begin
                // Every remaining try fails at once; the legacy path then waits.
                r.ph  = PH_LEGACY;
                r.att = '0;
                r.wk  = WK_TX;
            end
        end
        return r;
    endfunction

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign lim       = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RETRY_LIMIT: prdata = {28'd0, retry_limit_reg};
            REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_reg};
            REG_TX_WAIT:     prdata = {24'd0, tx_wait_reg};
            REG_LEGACY_GAP:  prdata = {24'd0, legacy_gap_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            tx_wait_reg     <= TX_WAIT_RST;
            legacy_gap_reg  <= LEGACY_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_RETRY_LIMIT: retry_limit_reg <= pwdata[3:0];
                REG_ACK_TIMEOUT: ack_timeout_reg <= pwdata[7:0];
                REG_TX_WAIT:     tx_wait_reg     <= pwdata[7:0];
                REG_LEGACY_GAP:  legacy_gap_reg  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // Decision for the transaction in the input register.
    always_comb
    begin
        logic [7:0]       mix;
        logic [IDX_W-1:0] bidx;
        logic             match;
        logic [7:0]       rx;

        ctl_next     = ctl_reg;
        ctl_next.em  = EM_NONE;
        ctl_next.cmd = CMD_LEGACY;
        ctl_next.ok  = 1'b0;
        cc_next      = cc_reg;
        sess_next    = sess_reg;
        target_next  = target_reg;
        ack_ok_next  = ack_ok_reg;
        ack_crc_next = ack_crc_reg;
        mix          = '0;
        rx           = in_reg.rx_byte;
        bidx         = ctl_reg.ack_cnt[IDX_W-1:0];
        match        = 1'b0;

        unique case (in_reg.mode)
            MODE_START:
            begin
                if (ctl_reg.ph == PH_IDLE)
                begin
                    cc_next     = cc_reg + 8'd1;
                    target_next = in_reg.node_id;
                    mix         = cc_next ^ in_reg.entropy ^ in_reg.node_id[7:0]
                                  ^ in_reg.node_id[15:8];
                    sess_next   = (mix == 8'd0) ? 8'd1 : mix;
                    ctl_next.ph  = PH_PREPARE;
                    ctl_next.att = '0;
                    ctl_next = start_try(ctl_next, in_reg.tx_busy, lim, tx_wait_reg);
                end
            end
            MODE_BYTE:
            begin
                if (ctl_reg.ph != PH_IDLE && ctl_reg.ph != PH_LEGACY
                    && ctl_reg.wk == WK_ACK && ctl_reg.ack_cnt < 4'(FRAME_BYTES))
                begin
                    // The acknowledgement is checked byte by byte as it arrives.
                    unique case (bidx)
                        3'd0:    match = (rx == ACK_HDR);
                        3'd1:    match = (rx == ACK_CMD);
                        3'd2:    match = (rx == target_reg[7:0]);
                        3'd3:    match = (rx == target_reg[15:8]);
                        3'd4:    match = (rx == target_reg[23:16]);
                        3'd5:    match = (rx == sess_reg);
                        3'd6:    match = (rx == ack_crc_reg);
                        default: match = (rx == ACK_TAIL);
                    endcase
                    ack_ok_next = (bidx == '0) ? match : (ack_ok_reg && match);
                    if (bidx == 3'd1)
                    begin
                        ack_crc_next = crc8_byte(8'd0, rx);
                    end
                    else if (bidx >= 3'd2 && bidx <= 3'd5)
                    begin
                        ack_crc_next = crc8_byte(ack_crc_reg, rx);
                    end
                    ctl_next.ack_cnt = ctl_reg.ack_cnt + 4'd1;
                    if (ctl_next.ack_cnt == 4'(FRAME_BYTES))
                    begin
                        if (!ack_ok_next)
                        begin
                            ctl_next = start_try(fail_try(ctl_next, lim), in_reg.tx_busy,
                                                 lim, tx_wait_reg);
                        end
                        else if (ctl_reg.ph == PH_RESET)
                        begin
                            ctl_next = finish(ctl_next, 1'b1);
                        end
                        else
                        begin
                            ctl_next.ph  = PH_RESET;
                            ctl_next.att = '0;
                            ctl_next = start_try(ctl_next, in_reg.tx_busy, lim, tx_wait_reg);
                        end
                    end
                end
            end
            MODE_TICK:
            begin
                if (ctl_reg.ph != PH_IDLE)
                begin
                    unique case (ctl_reg.wk)
                        WK_TX:
                        begin
                            if (ctl_reg.ph == PH_LEGACY)
                            begin
                                // The legacy path waits for the transmitter without limit.
                                if (!in_reg.tx_busy)
                                begin
                                    ctl_next = start_try(ctl_next, 1'b0, lim, tx_wait_reg);
                                end
                            end
                            else
                            begin
                                ctl_next.tc = ctl_reg.tc + 8'd1;
                                if (!in_reg.tx_busy)
                                begin
                                    ctl_next = send_cmd(ctl_next);
                                end
                                else if (ctl_next.tc >= tx_wait_reg)
                                begin
                                    ctl_next = start_try(fail_try(ctl_next, lim),
                                                         in_reg.tx_busy, lim, tx_wait_reg);
                                end
                            end
                        end
                        WK_ACK:
                        begin
                            ctl_next.tc = ctl_reg.tc + 8'd1;
                            if (ctl_next.tc >= ack_timeout_reg)
                            begin
                                ctl_next = start_try(fail_try(ctl_next, lim),
                                                     in_reg.tx_busy, lim, tx_wait_reg);
                            end
                        end
                        default:
                        begin
                            ctl_next.tc = ctl_reg.tc + 8'd1;
                            if (ctl_next.tc >= legacy_gap_reg)
                            begin
                                ctl_next.att = ctl_reg.att + 4'd1;
                                ctl_next = start_try(ctl_next, in_reg.tx_busy, lim,
                                                     tx_wait_reg);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Handshake between input register and output job register.
    assign job_last = job_done_reg || (job_idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign job_free = !job_valid_reg || (out_ready && job_last);
    assign advance  = in_valid_reg && (ctl_next.em == EM_NONE || job_free);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '{ph: PH_IDLE, wk: WK_TX, att: '0, tc: '0, ack_cnt: '0,
                             em: EM_NONE, cmd: '0, ok: 1'b0};
            cc_reg      <= '0;
            sess_reg    <= '0;
            target_reg  <= '0;
            ack_ok_reg  <= 1'b0;
            ack_crc_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg     <= ctl_next;
            cc_reg      <= cc_next;
            sess_reg    <= sess_next;
            target_reg  <= target_next;
            ack_ok_reg  <= ack_ok_next;
            ack_crc_reg <= ack_crc_next;
        end
    end

    // Frame byte selection; the CRC is accumulated as bytes one to five leave.
    always_comb
    begin
        unique case (job_idx_reg)
            3'd0:    frame_byte = TX_HDR;
            3'd1:    frame_byte = job_cmd_reg;
            3'd2:    frame_byte = job_id_reg[7:0];
            3'd3:    frame_byte = job_id_reg[15:8];
            3'd4:    frame_byte = job_id_reg[23:16];
            3'd5:    frame_byte = job_seq_reg;
            3'd6:    frame_byte = job_crc_reg;
            default: frame_byte = TX_TAIL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= '0;
        end
        else if (advance && ctl_next.em != EM_NONE)
        begin
            job_valid_reg <= 1'b1;
            job_idx_reg   <= '0;
        end
        else if (job_valid_reg && out_ready)
        begin
            if (job_last)
            begin
                job_valid_reg <= 1'b0;
            end
            else
            begin
                job_idx_reg <= job_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctl_next.em != EM_NONE)
        begin
            job_done_reg <= (ctl_next.em == EM_FINISH);
            job_ok_reg   <= ctl_next.ok;
            job_cmd_reg  <= ctl_next.cmd;
            job_id_reg   <= (ctl_next.cmd == CMD_LEGACY) ? 24'd0 : target_next;
            job_seq_reg  <= (ctl_next.cmd == CMD_LEGACY) ? 8'd0 : sess_next;
            job_crc_reg  <= '0;
        end
        else if (job_valid_reg && out_ready && job_idx_reg >= 3'd1 && job_idx_reg <= 3'd5)
        begin
            job_crc_reg <= crc8_byte(job_crc_reg, frame_byte);
        end
    end

    assign out_valid        = job_valid_reg;
    assign out_data.kind    = job_done_reg ? KIND_DONE : KIND_BYTE;
    assign out_data.tx_byte = job_done_reg ? 8'd0 : frame_byte;
    assign out_data.last    = !job_done_reg && (job_idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign out_data.success = job_done_reg && job_ok_reg;

    // A running handshake always carries a nonzero session number.
    a_session_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.ph != PH_IDLE |-> sess_reg != 8'd0)
        else $error("session number is zero while a handshake runs");

    a_ack_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.ack_cnt <= 4'(FRAME_BYTES))
        else $error("acknowledgement byte count past frame length");

    // Only a frame advances past its first byte.
    a_mid_frame_kind: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && job_idx_reg != '0 |-> !job_done_reg)
        else $error("finish result in the middle of a frame");

    // Once a frame byte other than the last is taken, the next byte is offered.
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.kind == KIND_BYTE && !out_data.last
        |=> out_valid && out_data.kind == KIND_BYTE)
        else $error("frame broken off before its last byte");

endmodule

// ----- test/update_entry_handshake_test.sv -----
module update_entry_handshake_test;
    import ueh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {STAGE_IDLE, STAGE_PREPARE, STAGE_RESET, STAGE_LEGACY} stage_t;
    typedef enum logic [1:0] {ON_TX, ON_ACK, ON_GAP} pause_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Register shadows and sequencer state of the predictor.
    logic [3:0]  cfg_retry;
    logic [7:0]  cfg_ack_wait;
    logic [7:0]  cfg_tx_wait;
    logic [7:0]  cfg_gap;
    logic [7:0]  calls;
    logic [7:0]  session;
    logic [23:0] target;
    stage_t      stage;
    pause_t      pause;
    logic [3:0]  tries;
    logic [7:0]  ticks;
    logic [7:0]  ack_buf [FRAME_BYTES];
    int          ack_len;

    out_item_t   predicted_link_q [$];

    bit          source_gaps;
    bit          sink_stalls;
    int          hold_off_cycles;
    int          cycles;
    int          mismatches;
    int          items_sent;
    int          frames_seen;
    int          wins;
    int          losses;

    update_entry_handshake DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] crc_of_five(input logic [39:0] bytes);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 5; i++)
        begin
            c = c ^ bytes[8*i +: 8];
            for (int b = 0; b < 8; b++)
            begin
                if (c[7])
                    c = {c[6:0], 1'b0} ^ CRC_POLY;
                else
                    c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic int tries_allowed();
        return (cfg_retry == 4'd0) ? 1 : int'(cfg_retry);
    endfunction

    function automatic void reset_sequencer();
        cfg_retry    = RETRY_LIMIT_RST;
        cfg_ack_wait = ACK_TIMEOUT_RST;
        cfg_tx_wait  = TX_WAIT_RST;
        cfg_gap      = LEGACY_GAP_RST;
        calls        = 8'h00;
        session      = 8'h00;
        target       = 24'h000000;
        stage        = STAGE_IDLE;
        pause        = ON_TX;
        tries        = 4'd0;
        ticks        = 8'h00;
        for (int i = 0; i < FRAME_BYTES; i++)
            ack_buf[i] = 8'h00;
        ack_len      = 0;
    endfunction

    function automatic void expect_frame(input logic [7:0] cmd, input logic [23:0] id,
                                         input logic [7:0] sid);
        logic [7:0] f [FRAME_BYTES];
        out_item_t  r;
        f[0] = TX_HDR;
        f[1] = cmd;
        f[2] = id[7:0];
        f[3] = id[15:8];
        f[4] = id[23:16];
        f[5] = sid;
        f[6] = crc_of_five({sid, id, cmd});
        f[7] = TX_TAIL;
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            r.kind    = KIND_BYTE;
            r.tx_byte = f[k];
            r.last    = (k == FRAME_BYTES - 1);
            r.success = 1'b0;
            predicted_link_q.push_back(r);
        end
    endfunction

    function automatic void expect_finish(input logic ok);
        out_item_t r;
        r.kind    = KIND_DONE;
        r.tx_byte = 8'h00;
        r.last    = 1'b0;
        r.success = ok;
        predicted_link_q.push_back(r);
        stage = STAGE_IDLE;
        pause = ON_TX;
        ticks = 8'h00;
    endfunction

    function automatic void issue_command();
        pause = ON_ACK;
        ticks = 8'h00;
        expect_frame((stage == STAGE_PREPARE) ? CMD_PREPARE : CMD_RESET, target, session);
    endfunction

    function automatic void try_failed();
        tries = tries + 4'd1;
        if (int'(tries) >= tries_allowed())
        begin
            stage = STAGE_LEGACY;
            tries = 4'd0;
        end
    endfunction

    // With a zero transmitter wait, a busy transmitter burns tries back to back
    // until the legacy stage is reached.
    function automatic void begin_try(input logic busy);
        logic done;
        done = 1'b0;
        while (!done)
        begin
            if (stage == STAGE_LEGACY)
            begin
                done = 1'b1;
                if (int'(tries) >= tries_allowed())
                    expect_finish(1'b0);
                else if (busy)
                    pause = ON_TX;
                else
                begin
                    pause = ON_GAP;
                    ticks = 8'h00;
                    expect_frame(CMD_LEGACY, 24'h000000, 8'h00);
                end
            end
            else
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                    ack_buf[i] = 8'h00;
                ack_len = 0;
                ticks   = 8'h00;
                if (!busy)
                begin
                    issue_command();
                    done = 1'b1;
                end
                else if (cfg_tx_wait != 8'h00)
                begin
                    pause = ON_TX;
                    done  = 1'b1;
                end
                else
                    try_failed();
            end
        end
    endfunction

    function automatic void take_tick(input logic busy);
        if (pause == ON_TX)
        begin
            // The legacy stage waits for the transmitter without a bound.
            if (stage == STAGE_LEGACY)
            begin
                if (!busy)
                    begin_try(busy);
            end
            else
            begin
                ticks = ticks + 8'd1;
                if (!busy)
                    issue_command();
                else if (ticks >= cfg_tx_wait)
                begin
                    try_failed();
                    begin_try(busy);
                end
            end
        end
        else if (pause == ON_ACK)
        begin
            ticks = ticks + 8'd1;
            if (ticks >= cfg_ack_wait)
            begin
                try_failed();
                begin_try(busy);
            end
        end
        else
        begin
            ticks = ticks + 8'd1;
            if (ticks >= cfg_gap)
            begin
                tries = tries + 4'd1;
                begin_try(busy);
            end
        end
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic busy);
        logic ok;
        if (pause == ON_ACK && stage != STAGE_LEGACY && ack_len < FRAME_BYTES)
        begin
            ack_buf[ack_len] = b;
            ack_len = ack_len + 1;
            if (ack_len == FRAME_BYTES)
            begin
                ok = ack_buf[0] == ACK_HDR && ack_buf[1] == ACK_CMD &&
                     ack_buf[2] == target[7:0] && ack_buf[3] == target[15:8] &&
                     ack_buf[4] == target[23:16] && ack_buf[5] == session &&
                     ack_buf[6] == crc_of_five({ack_buf[5], ack_buf[4], ack_buf[3],
                                                ack_buf[2], ack_buf[1]}) &&
                     ack_buf[7] == ACK_TAIL;
                if (!ok)
                begin
                    try_failed();
                    begin_try(busy);
                end
                else if (stage == STAGE_RESET)
                    expect_finish(1'b1);
                else
                begin
                    stage = STAGE_RESET;
                    tries = 4'd0;
                    begin_try(busy);
                end
            end
        end
    endfunction

    function automatic void advance_sequencer(input in_item_t item);
        case (item.mode)
            MODE_START:
            begin
                if (stage == STAGE_IDLE)
                begin
                    calls   = calls + 8'd1;
                    target  = item.node_id;
                    session = calls ^ item.entropy ^ item.node_id[7:0] ^ item.node_id[15:8];
                    if (session == 8'h00)
                        session = 8'h01;
                    stage = STAGE_PREPARE;
                    tries = 4'd0;
                    begin_try(item.tx_busy);
                end
            end
            MODE_BYTE:
            begin
                if (stage != STAGE_IDLE)
                    take_byte(item.rx_byte, item.tx_busy);
            end
            MODE_TICK:
            begin
                if (stage != STAGE_IDLE)
                    take_tick(item.tx_busy);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Acknowledgement that the device would return for the running session.
    function automatic logic [63:0] ready_ack();
        logic [7:0] c;
        c = crc_of_five({session, target, ACK_CMD});
        return {ACK_TAIL, c, session, target, ACK_CMD, ACK_HDR};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t make_item(input logic [1:0] mode, input logic [23:0] id,
                                           input logic [7:0] ent, input logic [7:0] rx,
                                           input logic busy);
        in_item_t item;
        item.mode    = mode;
        item.node_id = id;
        item.entropy = ent;
        item.rx_byte = rx;
        item.tx_busy = busy;
        return item;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_sequencer(item);
        items_sent++;
    endtask

    task automatic send_tick(input logic busy);
        send_item(make_item(MODE_TICK, 24'($urandom), 8'($urandom), 8'($urandom), busy));
    endtask

    task automatic send_ack(input logic corrupt, input logic busy_at_end);
        logic [63:0] frame;
        int          pos;
        frame = ready_ack();
        if (corrupt)
        begin
            pos = $urandom_range(0, FRAME_BYTES - 1);
            frame[8*pos +: 8] = frame[8*pos +: 8] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < FRAME_BYTES; k++)
            send_item(make_item(MODE_BYTE, 24'($urandom), 8'($urandom), frame[8*k +: 8],
                                (k == FRAME_BYTES - 1) ? busy_at_end : 1'($urandom)));
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_link_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_RETRY_LIMIT: cfg_retry    = value[3:0];
            REG_ACK_TIMEOUT: cfg_ack_wait = value[7:0];
            REG_TX_WAIT:     cfg_tx_wait  = value[7:0];
            REG_LEGACY_GAP:  cfg_gap      = value[7:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            mismatches++;
            $display("%0t: register %0d expected %h actual %h", $time, idx, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_all_regs();
        check_reg(REG_RETRY_LIMIT, {28'd0, cfg_retry});
        check_reg(REG_ACK_TIMEOUT, {24'd0, cfg_ack_wait});
        check_reg(REG_TX_WAIT, {24'd0, cfg_tx_wait});
        check_reg(REG_LEGACY_GAP, {24'd0, cfg_gap});
    endtask

    task automatic set_registers(input logic [3:0] retry, input logic [7:0] ack_wait,
                                 input logic [7:0] tx_wait, input logic [7:0] gap);
        write_reg(REG_RETRY_LIMIT, {28'd0, retry});
        write_reg(REG_ACK_TIMEOUT, {24'd0, ack_wait});
        write_reg(REG_TX_WAIT, {24'd0, tx_wait});
        write_reg(REG_LEGACY_GAP, {24'd0, gap});
        check_all_regs();
    endtask

    // Short waits and ticks with a free transmitter bring any running handshake
    // to its end in a few dozen ticks at most.
    task automatic run_to_idle();
        if (stage != STAGE_IDLE)
        begin
            drain_outputs();
            set_registers(cfg_retry, 8'd1, 8'd1, 8'd0);
        end
        while (stage != STAGE_IDLE)
            send_tick(1'b0);
        drain_outputs();
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (predicted_link_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected transaction kind %0d byte %h last %0d success %0d",
                     $time, got.kind, got.tx_byte, got.last, got.success);
        end
        else
        begin
            want = predicted_link_q.pop_front();
            compare_field("kind", 8'(want.kind), 8'(got.kind));
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("last", 8'(want.last), 8'(got.last));
            compare_field("success", 8'(want.success), 8'(got.success));
            if (want.kind == KIND_DONE)
            begin
                if (want.success)
                    wins++;
                else
                    losses++;
            end
            else if (want.last)
                frames_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    initial
    begin
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 99) < 30)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("update_entry_handshake: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_reset_values();
        check_all_regs();
    endtask

    // Both commands acknowledged at once; a second start, an unused mode and a
    // tick fall into the acknowledgement wait and must change nothing.
    task automatic test_acknowledged_handshake();
        send_item(make_item(MODE_START, 24'hFFFFFF, 8'hFF, 8'($urandom), 1'b0));
        send_item(make_item(MODE_START, 24'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_item(make_item(MODE_SPARE, 24'($urandom), 8'($urandom), 8'($urandom), 1'b1));
        send_tick(1'b1);
        send_ack(1'b0, 1'b0);
        send_ack(1'b0, 1'b0);
        drain_outputs();
    endtask

    task automatic test_fallback_corners();
        logic [23:0] id;
        set_registers(4'd0, 8'd0, 8'd0, 8'd0);
        // Entropy is picked so that the mixed session comes out zero.
        id = 24'($urandom);
        send_item(make_item(MODE_START, id, (calls + 8'd1) ^ id[7:0] ^ id[15:8],
                            8'($urandom), 1'b0));
        send_tick(1'b0);
        send_item(make_item(MODE_BYTE, 24'($urandom), 8'($urandom), ACK_HDR, 1'b0));
        send_tick(1'b0);
        // A busy transmitter with no wait allowed fails the try on the spot.
        send_item(make_item(MODE_START, 24'h000000, 8'h00, 8'($urandom), 1'b1));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_outputs();
    endtask

    // Each tick while the handshake runs ends a try and sends a frame or the finish
    // result, so the block backs up while the receiver holds off.
    task automatic test_output_backpressure();
        set_registers(4'd15, 8'd1, 8'd0, 8'd0);
        source_gaps     = 1'b0;
        sink_stalls     = 1'b0;
        hold_off_cycles = 400;
        send_item(make_item(MODE_START, 24'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        repeat (40)
            send_tick(1'b0);
        drain_outputs();
    endtask

    task automatic random_step();
        int          r;
        int          cut;
        logic [23:0] id;
        logic [63:0] frame;
        r = $urandom_range(0, 99);
        if (stage == STAGE_IDLE)
        begin
            if (r < 8)
                send_item(make_item((r < 4) ? MODE_BYTE : MODE_TICK, 24'($urandom),
                                    8'($urandom), 8'($urandom), 1'($urandom)));
            else
            begin
                id = (r < 18) ? 24'h000000 : (r < 28) ? 24'hFFFFFF : 24'($urandom);
                send_item(make_item(MODE_START, id, 8'($urandom), 8'($urandom),
                                    $urandom_range(0, 4) == 0));
            end
        end
        else if (pause == ON_ACK && r < 55)
            send_ack($urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
        else if (r < 88)
            send_tick($urandom_range(0, 9) < 3);
        else
        begin
            case ($urandom_range(0, 3))
                0: send_item(make_item(MODE_START, 24'($urandom), 8'($urandom),
                                       8'($urandom), 1'($urandom)));
                1: send_item(make_item(MODE_BYTE, 24'($urandom), 8'($urandom),
                                       8'($urandom), 1'($urandom)));
                2: send_item(make_item(MODE_SPARE, 24'($urandom), 8'($urandom),
                                       8'($urandom), 1'($urandom)));
                default:
                begin
                    // A cut-off acknowledgement leaves the collector part full.
                    frame = ready_ack();
                    cut   = $urandom_range(1, FRAME_BYTES - 1);
                    for (int k = 0; k < cut; k++)
                        send_item(make_item(MODE_BYTE, 24'($urandom), 8'($urandom),
                                            frame[8*k +: 8], 1'($urandom)));
                end
            endcase
        end
    endtask

    task automatic run_random_phase(input logic [3:0] retry, input logic [7:0] ack_wait,
                                    input logic [7:0] tx_wait, input logic [7:0] gap,
                                    input int budget);
        int first;
        run_to_idle();
        set_registers(retry, ack_wait, tx_wait, gap);
        first = items_sent;
        while (items_sent - first < budget)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                source_gaps = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 59) == 0)
                drain_outputs();
            random_step();
        end
    endtask

    task automatic test_random_traffic();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        run_random_phase(4'd2, 8'd4, 8'd3, 8'd2, 85);
        run_random_phase(4'd15, 8'd1, 8'd0, 8'd0, 85);
        run_random_phase(4'd1, 8'd255, 8'd255, 8'd255, 85);
        run_random_phase(4'd4, 8'd6, 8'd2, 8'd1, 50);
        run_to_idle();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 4'd0;
        pwdata     <= 32'd0;
        cycles     <= 0;
        source_gaps     = 1'b0;
        sink_stalls     = 1'b0;
        hold_off_cycles = 0;
        mismatches      = 0;
        items_sent      = 0;
        frames_seen     = 0;
        wins            = 0;
        losses          = 0;
        reset_sequencer();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset_values();
        test_acknowledged_handshake();
        test_fallback_corners();
        test_output_backpressure();
        test_random_traffic();
        drain_outputs();

        $display("Sent %0d input transactions; checked %0d frames, %0d handshakes won and %0d lost.",
                 items_sent, frames_seen, wins, losses);
        $display("Retry limits 0 to 15 and waits 0 to 255 were used, with long output stalls.");
        if (mismatches == 0)
            $display("update_entry_handshake: match");
        else
            $display("update_entry_handshake: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ueh_pkg.sv
hw/rtl/update_entry_handshake.sv
test/update_entry_handshake_test.sv
